// ===== design/mrfc_pkg.sv =====
// Package for the Modbus response frame checker: frame constants and
// the byte-wide CRC-16 update. No dependencies.
package mrfc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned VALUE_W = 32;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [LEN_W-1:0] LEN_READ16 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_READ32 = 3'd7;
    localparam logic [IDX_W-1:0] DATA_START = 4'd3;
    localparam logic [IDX_W-1:0] IDX_MAX    = 4'd8;

    // Reflected CRC-16 over one byte, eight bit steps unrolled.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/modbus_response_frame_checker.sv =====
// Modbus RTU response frame checker: byte counter, CRC-16, data capture
// and a registered result stage. Depends on mrfc_pkg.
//
// channel | direction | handshake                 | payload
// rx      | in        | i_rx_valid / o_rx_ready   | i_rx_byte
// res     | out       | o_res_valid / i_res_ready | o_crc_ok, o_value
// cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_payload_len
//
// One byte per cycle while o_rx_ready is high; the CRC byte update feeds
// the frame CRC, checked against the received CRC bytes. A result appears
// in the cycle after the last frame byte is accepted. o_rx_ready drops
// only while a held result is not taken. Synchronous active-low reset:
// payload_len 5, frame state cleared, CRC 16'hFFFF. cfg is always ready.
module modbus_response_frame_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [mrfc_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic                              o_crc_ok,
    output logic [mrfc_pkg::VALUE_W-1:0]      o_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mrfc_pkg::LEN_W-1:0]        i_cfg_payload_len
);

    logic [mrfc_pkg::LEN_W-1:0]   r_payload_len;
    logic [mrfc_pkg::IDX_W-1:0]   r_byte_index, n_byte_index;
    logic [mrfc_pkg::CRC_W-1:0]   r_crc, n_crc;
    logic [mrfc_pkg::VALUE_W-1:0] r_data, n_data;
    logic [mrfc_pkg::BYTE_W-1:0]  r_crc_lo, n_crc_lo;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_ok, n_out_ok;
    logic [mrfc_pkg::VALUE_W-1:0] r_out_value, n_out_value;

    logic [mrfc_pkg::LEN_W-1:0]   len;
    logic [mrfc_pkg::IDX_W-1:0]   len_x;
    logic                         rx_acc;
    logic                         last_byte;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_out_valid || i_res_ready;
    assign rx_acc      = i_rx_valid && o_rx_ready;

    assign len       = (r_payload_len < mrfc_pkg::LEN_READ16) ? mrfc_pkg::LEN_READ16
                                                              : r_payload_len;
    assign len_x     = {1'b0, len};
    assign last_byte = r_byte_index > len_x;

    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_data       = r_data;
        n_crc_lo     = r_crc_lo;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_ok     = r_out_ok;
        n_out_value  = r_out_value;
        if (rx_acc) begin
            if (last_byte) begin
                n_out_valid = 1'b1;
                n_out_ok    = (r_crc[7:0] == r_crc_lo) && (r_crc[15:8] == i_rx_byte);
                priority if (len == mrfc_pkg::LEN_READ16) begin
                    n_out_value = {16'h0000, r_data[15:0]};
                end else if (len == mrfc_pkg::LEN_READ32) begin
                    n_out_value = r_data;
                end else begin
                    n_out_value = '0;
                end
                n_byte_index = '0;
                n_crc        = mrfc_pkg::CRC_INIT;
                n_data       = '0;
                n_crc_lo     = '0;
            end else begin
                if (r_byte_index < len_x) begin
                    n_crc = mrfc_pkg::crc_byte(r_crc, i_rx_byte);
                    if (r_byte_index >= mrfc_pkg::DATA_START) begin
                        n_data = {r_data[mrfc_pkg::VALUE_W-mrfc_pkg::BYTE_W-1:0], i_rx_byte};
                    end
                end else begin
                    n_crc_lo = i_rx_byte;
                end
                n_byte_index = r_byte_index + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= mrfc_pkg::LEN_READ16;
            r_byte_index  <= '0;
            r_crc         <= mrfc_pkg::CRC_INIT;
            r_data        <= '0;
            r_crc_lo      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_payload_len <= i_cfg_payload_len;
            end
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_data       <= n_data;
            r_crc_lo     <= n_crc_lo;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_out_ok;
        r_out_value <= n_out_value;
    end

    assign o_res_valid = r_out_valid;
    assign o_crc_ok    = r_out_ok;
    assign o_value     = r_out_value;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= mrfc_pkg::IDX_MAX)
        else $error("byte index beyond frame");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_acc && last_byte |=> r_byte_index == '0 && r_crc == mrfc_pkg::CRC_INIT
                                && r_out_valid)
        else $error("frame did not restart with a result");

    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_acc && !last_byte && !(r_out_valid && !i_res_ready) |=> !r_out_valid)
        else $error("result without last byte");

endmodule
